FILE: hw/rtl/cisf_pkg.sv
// shared types, constants and the case fold for the substring finder
package cisf_pkg;

	localparam int CHAR_W              = 8;
	localparam int POS_W               = 16;
	localparam int PATTERN_MAX_DEF     = 32;
	localparam int TEXT_INDEX_BITS_DEF = 16;

	localparam logic OP_PATTERN = 1'b0;
	localparam logic OP_TEXT    = 1'b1;

	// pattern store control
	typedef struct packed {
		logic load;
		logic restart;
	} cisf_pat_ctl_t;

	// text window control
	typedef struct packed {
		logic step;
		logic clear;
	} cisf_txt_ctl_t;

	function automatic logic [CHAR_W-1:0] fold_lower(input logic [CHAR_W-1:0] c);
		logic [CHAR_W-1:0] r;
		r = c;
		if (c >= 8'h41 && c <= 8'h5a) begin
			r = c + 8'h20;
		end
		return r;
	endfunction

endpackage

FILE: hw/rtl/cisf_pattern.sv
// pattern shift register, length and overflow flag
module cisf_pattern #(
	parameter int PATTERN_MAX = cisf_pkg::PATTERN_MAX_DEF,
	parameter int LEN_W       = $clog2(PATTERN_MAX + 1)
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  cisf_pkg::cisf_pat_ctl_t                       ctl,
	input  logic [cisf_pkg::CHAR_W-1:0]                   char_fold,
	output logic [PATTERN_MAX-1:0][cisf_pkg::CHAR_W-1:0]  pat,
	output logic [LEN_W-1:0]                              pat_len,
	output logic                                          overflow
);
	import cisf_pkg::*;

	// newest pattern byte sits at index 0, so pat[k] lines up with window[k]
	logic [PATTERN_MAX-1:0][CHAR_W-1:0] pat_q;
	logic [LEN_W-1:0]                   len_q;
	logic                               ovf_q;
	logic [LEN_W-1:0]                   len_eff;
	logic                               ovf_eff;
	logic                               room;

	assign len_eff = ctl.restart ? '0 : len_q;
	assign ovf_eff = ctl.restart ? 1'b0 : ovf_q;
	assign room    = len_eff < LEN_W'(PATTERN_MAX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			ovf_q <= 1'b0;
		end else if (ctl.load) begin
			if (room) begin
				len_q <= len_eff + LEN_W'(1);
				ovf_q <= ovf_eff;
			end else begin
				len_q <= len_eff;
				ovf_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load && room) begin
			for (int k = PATTERN_MAX - 1; k > 0; k--) begin
				pat_q[k] <= pat_q[k-1];
			end
			pat_q[0] <= char_fold;
		end
	end

	assign pat      = pat_q;
	assign pat_len  = len_q;
	assign overflow = ovf_q;

endmodule

FILE: hw/rtl/cisf_window.sv
// text window shift register, text index and first-match tracking
module cisf_window #(
	parameter int PATTERN_MAX     = cisf_pkg::PATTERN_MAX_DEF,
	parameter int TEXT_INDEX_BITS = cisf_pkg::TEXT_INDEX_BITS_DEF,
	parameter int LEN_W           = $clog2(PATTERN_MAX + 1)
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  cisf_pkg::cisf_txt_ctl_t                       ctl,
	input  logic [cisf_pkg::CHAR_W-1:0]                   char_fold,
	input  logic [PATTERN_MAX-1:0][cisf_pkg::CHAR_W-1:0]  pat,
	input  logic [LEN_W-1:0]                              pat_len,
	output logic                                          seen_nx,
	output logic [TEXT_INDEX_BITS-1:0]                    start_nx
);
	import cisf_pkg::*;

	localparam int CNT_W = TEXT_INDEX_BITS + 1;
	localparam int CMP_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;

	logic [PATTERN_MAX-1:0][CHAR_W-1:0] win_q;
	logic [PATTERN_MAX-1:0][CHAR_W-1:0] win_nx;
	logic [CNT_W-1:0]                   cnt_q;
	logic [CNT_W-1:0]                   cnt_nx;
	logic                               seen_q;
	logic [TEXT_INDEX_BITS-1:0]         start_q;
	logic                               cnt_open;
	logic [CMP_W-1:0]                   inc_ext;
	logic [CMP_W-1:0]                   len_ext;
	logic [CMP_W-1:0]                   start_full;
	logic [PATTERN_MAX-1:0]             lane_ok;
	logic                               hit;

	always_comb begin
		win_nx[0] = char_fold;
		for (int k = 1; k < PATTERN_MAX; k++) begin
			win_nx[k] = win_q[k-1];
		end
	end

	// lanes past the pattern length always agree
	always_comb begin
		for (int k = 0; k < PATTERN_MAX; k++) begin
			lane_ok[k] = (CMP_W'(k) >= CMP_W'(pat_len)) || (win_nx[k] == pat[k]);
		end
	end

	assign cnt_open   = cnt_q != {CNT_W{1'b1}};
	assign cnt_nx     = cnt_open ? cnt_q + CNT_W'(1) : cnt_q;
	assign inc_ext    = CMP_W'(cnt_q) + CMP_W'(1);
	assign len_ext    = CMP_W'(pat_len);
	assign start_full = inc_ext - len_ext;

	// matches starting beyond the index range are not reported
	assign hit = cnt_open && !seen_q && (pat_len != '0) && (inc_ext >= len_ext)
		&& (start_full[CMP_W-1:TEXT_INDEX_BITS] == '0) && (&lane_ok);

	assign seen_nx  = seen_q || hit;
	assign start_nx = hit ? start_full[TEXT_INDEX_BITS-1:0] : start_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			seen_q  <= 1'b0;
			start_q <= '0;
		end else if (ctl.clear) begin
			cnt_q   <= '0;
			seen_q  <= 1'b0;
			start_q <= '0;
		end else if (ctl.step) begin
			cnt_q   <= cnt_nx;
			seen_q  <= seen_nx;
			start_q <= start_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.step) begin
			win_q <= win_nx;
		end
	end

endmodule

FILE: hw/rtl/case_insensitive_substring_find.sv
// top level: input register, pattern and window units, result register
//
//  channel  direction  handshake             payload
//  in       sink       in_valid / in_ready   opcode, char_in, last
//  out      source     out_valid / out_ready found, position, pattern_too_long
//
// one item per cycle while no last text byte is held back; an item updates
// state (pattern shift, window compare over PATTERN_MAX lanes) as it leaves
// the input register, and a last text byte then loads the output register.
// arst_n clears lengths, internal flags and valids; pattern and window bytes
// and result payload are not reset. a last text byte waits in the input
// register only while an earlier result sits unread in the output register.
module case_insensitive_substring_find #(
	parameter int PATTERN_MAX     = cisf_pkg::PATTERN_MAX_DEF,
	parameter int TEXT_INDEX_BITS = cisf_pkg::TEXT_INDEX_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             opcode,
	input  logic [cisf_pkg::CHAR_W-1:0]      char_in,
	input  logic                             last,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             found,
	output logic [cisf_pkg::POS_W-1:0]       position,
	output logic                             pattern_too_long
);
	import cisf_pkg::*;

	localparam int LEN_W = $clog2(PATTERN_MAX + 1);

	logic                               vld_s1;
	logic                               op_s1;
	logic [CHAR_W-1:0]                  char_s1;
	logic                               last_s1;
	logic                               phase_q;
	logic                               out_vld_q;
	logic                               found_q;
	logic [POS_W-1:0]                   pos_q;
	logic                               ovf_out_q;

	logic [CHAR_W-1:0]                  char_fold;
	logic                               gives_result;
	logic                               adv;
	logic                               is_text;
	cisf_pat_ctl_t                      pat_ctl;
	cisf_txt_ctl_t                      txt_ctl;
	logic [PATTERN_MAX-1:0][CHAR_W-1:0] pat;
	logic [LEN_W-1:0]                   pat_len;
	logic                               overflow;
	logic                               seen_nx;
	logic [TEXT_INDEX_BITS-1:0]         start_nx;

	assign char_fold    = fold_lower(char_s1);
	assign is_text      = op_s1 == OP_TEXT;
	assign gives_result = is_text && last_s1;
	assign adv          = vld_s1 && (!gives_result || !out_vld_q || out_ready);
	assign in_ready     = !vld_s1 || adv;

	// a pattern byte after any text byte starts a new pattern
	assign pat_ctl.load    = adv && !is_text;
	assign pat_ctl.restart = adv && !is_text && phase_q;
	assign txt_ctl.step    = adv && is_text;
	assign txt_ctl.clear   = (adv && gives_result) || pat_ctl.restart;

	cisf_pattern #(
		.PATTERN_MAX (PATTERN_MAX),
		.LEN_W       (LEN_W)
	) u_pattern (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (pat_ctl),
		.char_fold (char_fold),
		.pat       (pat),
		.pat_len   (pat_len),
		.overflow  (overflow)
	);

	cisf_window #(
		.PATTERN_MAX     (PATTERN_MAX),
		.TEXT_INDEX_BITS (TEXT_INDEX_BITS),
		.LEN_W           (LEN_W)
	) u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (txt_ctl),
		.char_fold (char_fold),
		.pat       (pat),
		.pat_len   (pat_len),
		.seen_nx   (seen_nx),
		.start_nx  (start_nx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			phase_q   <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (in_ready) begin
				vld_s1 <= in_valid;
			end
			if (adv) begin
				phase_q <= is_text;
			end
			if (adv && gives_result) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			op_s1   <= opcode;
			char_s1 <= char_in;
			last_s1 <= last;
		end
		if (adv && gives_result) begin
			found_q   <= seen_nx;
			pos_q     <= seen_nx ? POS_W'(start_nx) : '0;
			ovf_out_q <= overflow;
		end
	end

	assign out_valid        = out_vld_q;
	assign found            = found_q;
	assign position         = pos_q;
	assign pattern_too_long = ovf_out_q;

endmodule
